// ===== rtl/core/cbmm_pkg.sv =====
// Shared constants and types for the console bus memory map.
// No dependencies; used by console_bus_memory_map and cbmm_rem_unit in rtl/core.
`default_nettype none

package cbmm_pkg;

  localparam int MAIN_RAM_DEPTH   = 4096;
  localparam int BOOT_ROM_BASE    = 61440;
  localparam int CART_OFFSET_BITS = 20;

  localparam int CART_SIZE_W = 21;
  localparam int BOOT_SIZE_W = 13;
  localparam int CFG_INDEX_W = 8;
  localparam int FETCH_W     = 20;
  localparam int DIVIDEND_W  = 15;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] SRC_INTERNAL = 2'd0;
  localparam logic [1:0] SRC_BOOT     = 2'd1;
  localparam logic [1:0] SRC_CART     = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_CART_SIZE = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_BOOT_SIZE = 8'd1;

  localparam logic [4:0] DISP_LIST_HI = 5'h0C;
  localparam logic [4:0] DISP_LIST_LO = 5'h10;

  localparam logic [15:0] ADDR_LEGACY0 = 16'h0000;
  localparam logic [15:0] ADDR_DISP0   = 16'h0020;
  localparam logic [15:0] ADDR_LOW0    = 16'h0040;
  localparam logic [15:0] ADDR_LEGACY1 = 16'h0100;
  localparam logic [15:0] ADDR_DISP1   = 16'h0120;
  localparam logic [15:0] ADDR_LOW1    = 16'h0140;
  localparam logic [15:0] ADDR_LEGACY2 = 16'h0200;
  localparam logic [15:0] ADDR_DISP2   = 16'h0220;
  localparam logic [15:0] ADDR_OPEN    = 16'h0240;
  localparam logic [15:0] ADDR_IO      = 16'h0480;
  localparam logic [15:0] ADDR_IO_END  = 16'h0500;
  localparam logic [15:0] ADDR_MAIN    = 16'h1800;
  localparam logic [15:0] ADDR_CART_LO = 16'h4000;
  localparam logic [15:0] ADDR_CART_HI = 16'hC000;
  localparam logic [CART_SIZE_W-1:0] CART_BANK = 21'd16384;
  localparam logic [7:0]  OPEN_BUS     = 8'hFF;

  typedef struct packed {
    logic                   done;
    logic [CART_SIZE_W-1:0] rem;
  } rem_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/console_bus_memory_map.sv =====
// Console bus memory map: one request at a time, accepted only in the idle state.
// Writes and register/open-bus/boot/top-bank reads go from execute to done; RAM
// reads add a RAM read state, lower cartridge window reads a bit-serial remainder.
// After reset a clearing pass over MAIN_RAM_DEPTH addresses zeroes all RAMs while
// in_stall is high; configuration writes are taken throughout.
// Depends on cbmm_pkg, cbmm_ram, cbmm_rem_unit.
`default_nettype none

module console_bus_memory_map #(
  parameter int MAIN_RAM_DEPTH   = cbmm_pkg::MAIN_RAM_DEPTH,
  parameter int BOOT_ROM_BASE    = cbmm_pkg::BOOT_ROM_BASE,
  parameter int CART_OFFSET_BITS = cbmm_pkg::CART_OFFSET_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic                               op,
  input  wire logic [15:0]                        bus_address,
  input  wire logic [7:0]                         write_byte,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic      [7:0]                         read_byte,
  output logic      [1:0]                         source,
  output logic      [cbmm_pkg::FETCH_W-1:0]       fetch_offset,
  output logic      [15:0]                        display_list_pointer,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [cbmm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [cbmm_pkg::CART_SIZE_W-1:0]   cfg_data
);

  localparam int MainAw = $clog2(MAIN_RAM_DEPTH);
  localparam int SzW    = cbmm_pkg::CART_SIZE_W;
  localparam int FW     = cbmm_pkg::FETCH_W;
  localparam logic [SzW:0] CartMask = (SzW+1)'((64'd1 << CART_OFFSET_BITS) - 64'd1);

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_EXEC, S_RAM, S_DIV, S_DONE} state_t;
  typedef enum logic [2:0] {R_NONE, R_LEGACY, R_DISPLAY, R_LOW, R_IO, R_MAIN} region_t;

  state_t      state;
  logic [MainAw-1:0] clr_cnt;

  logic        op_q;
  logic [15:0] addr;
  logic [7:0]  wbyte;

  logic [7:0]  legacy_regs  [32];
  logic [7:0]  display_regs [32];
  logic [15:0] list_pointer;
  logic [SzW-1:0] cart_size;
  logic [cbmm_pkg::BOOT_SIZE_W-1:0] boot_size;

  logic [7:0]  res_byte;
  logic [1:0]  res_src;
  logic [FW-1:0] res_off;

  logic [7:0]  exec_byte;
  logic [1:0]  exec_src;
  logic [FW-1:0] exec_off;
  state_t      exec_next;

  region_t     region;
  logic [4:0]  reg_idx;
  logic [7:0]  low_idx;
  logic [6:0]  io_idx;
  logic [MainAw-1:0] main_idx;

  logic        clearing;
  logic        exec_wr;
  logic        boot_hit;
  logic [15:0] boot_off;
  logic [15:0] cart_rel;
  logic [SzW:0] top_sum;

  logic        low_we, io_we, main_we;
  logic [7:0]  low_waddr;
  logic [6:0]  io_waddr;
  logic [MainAw-1:0] main_waddr;
  logic [7:0]  ram_wdata;
  logic [7:0]  low_rdata, io_rdata, main_rdata;

  logic        div_start;
  cbmm_pkg::rem_status_t div_status;

  always_comb begin
    region   = R_NONE;
    reg_idx  = addr[4:0];
    io_idx   = addr[6:0];
    low_idx  = (addr < cbmm_pkg::ADDR_LEGACY1) ? (addr[7:0] - cbmm_pkg::ADDR_LOW0[7:0])
                                               : addr[7:0];
    main_idx = MainAw'(addr - cbmm_pkg::ADDR_MAIN);
    if (addr < cbmm_pkg::ADDR_DISP0) begin
      region = R_LEGACY;
    end else if (addr < cbmm_pkg::ADDR_LOW0) begin
      region = R_DISPLAY;
    end else if (addr < cbmm_pkg::ADDR_LEGACY1) begin
      region = R_LOW;
    end else if (addr < cbmm_pkg::ADDR_DISP1) begin
      region = R_LEGACY;
    end else if (addr < cbmm_pkg::ADDR_LOW1) begin
      region = R_DISPLAY;
    end else if (addr < cbmm_pkg::ADDR_LEGACY2) begin
      region = R_LOW;
    end else if (addr < cbmm_pkg::ADDR_DISP2) begin
      region = R_LEGACY;
    end else if (addr < cbmm_pkg::ADDR_OPEN) begin
      region = R_DISPLAY;
    end else if (addr >= cbmm_pkg::ADDR_IO && addr < cbmm_pkg::ADDR_IO_END) begin
      region = R_IO;
    end else if ({1'b0, addr} >= {1'b0, cbmm_pkg::ADDR_MAIN} &&
                 {1'b0, addr} < ({1'b0, cbmm_pkg::ADDR_MAIN} + 17'(MAIN_RAM_DEPTH))) begin
      region = R_MAIN;
    end
  end

  always_comb begin
    boot_hit = (boot_size != '0) && ({1'b0, addr} >= 17'(BOOT_ROM_BASE)) &&
               ({1'b0, addr} < (17'(BOOT_ROM_BASE) + 17'(boot_size)));
    boot_off = addr - 16'(BOOT_ROM_BASE);
    cart_rel = addr - cbmm_pkg::ADDR_CART_LO;
    top_sum  = ((SzW+1)'(addr - cbmm_pkg::ADDR_CART_HI) +
                (SzW+1)'(cart_size - cbmm_pkg::CART_BANK)) & CartMask;
  end

  always_comb begin
    exec_byte = 8'h00;
    exec_src  = cbmm_pkg::SRC_INTERNAL;
    exec_off  = '0;
    exec_next = S_DONE;
    if (op_q == cbmm_pkg::OP_WRITE) begin
      exec_next = S_DONE;
    end else if (addr >= cbmm_pkg::ADDR_CART_LO) begin
      exec_byte = cbmm_pkg::OPEN_BUS;
      if (boot_hit) begin
        exec_byte = 8'h00;
        exec_src  = cbmm_pkg::SRC_BOOT;
        exec_off  = FW'(boot_off);
      end else if (addr >= cbmm_pkg::ADDR_CART_HI) begin
        if (cart_size >= cbmm_pkg::CART_BANK) begin
          exec_byte = 8'h00;
          exec_src  = cbmm_pkg::SRC_CART;
          exec_off  = top_sum[FW-1:0];
        end
      end else if (cart_size != '0) begin
        exec_next = S_DIV;
      end
    end else begin
      unique case (region) inside
        R_LEGACY:              exec_byte = legacy_regs[reg_idx];
        R_DISPLAY:             exec_byte = display_regs[reg_idx];
        R_LOW, R_IO, R_MAIN:   exec_next = S_RAM;
        default:               exec_byte = cbmm_pkg::OPEN_BUS;
      endcase
    end
  end

  assign clearing = (state == S_CLEAR);
  assign exec_wr  = (state == S_EXEC) && (op_q == cbmm_pkg::OP_WRITE);

  always_comb begin
    low_we     = clearing || (exec_wr && region == R_LOW);
    io_we      = clearing || (exec_wr && region == R_IO);
    main_we    = clearing || (exec_wr && region == R_MAIN);
    low_waddr  = clearing ? clr_cnt[7:0] : low_idx;
    io_waddr   = clearing ? clr_cnt[6:0] : io_idx;
    main_waddr = clearing ? clr_cnt : main_idx;
    ram_wdata  = clearing ? 8'h00 : wbyte;
  end

  assign div_start = (state == S_EXEC) && (op_q == cbmm_pkg::OP_READ) &&
                     (addr >= cbmm_pkg::ADDR_CART_LO) && !boot_hit &&
                     (addr < cbmm_pkg::ADDR_CART_HI) && (cart_size != '0);

  cbmm_ram #(.WIDTH(8), .DEPTH(256)) u_low_ram (
    .clk(clk), .we(low_we), .waddr(low_waddr), .wdata(ram_wdata),
    .raddr(low_idx), .rdata(low_rdata)
  );

  cbmm_ram #(.WIDTH(8), .DEPTH(128)) u_io_ram (
    .clk(clk), .we(io_we), .waddr(io_waddr), .wdata(ram_wdata),
    .raddr(io_idx), .rdata(io_rdata)
  );

  cbmm_ram #(.WIDTH(8), .DEPTH(MAIN_RAM_DEPTH)) u_main_ram (
    .clk(clk), .we(main_we), .waddr(main_waddr), .wdata(ram_wdata),
    .raddr(main_idx), .rdata(main_rdata)
  );

  cbmm_rem_unit u_rem (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(cart_rel[cbmm_pkg::DIVIDEND_W-1:0]),
    .divisor(cart_size), .status(div_status)
  );

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_cnt      <= '0;
      list_pointer <= '0;
      cart_size    <= '0;
      boot_size    <= '0;
      out_valid    <= 1'b0;
      for (int i = 0; i < 32; i++) begin
        legacy_regs[i]  <= 8'h00;
        display_regs[i] <= 8'h00;
      end
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          cbmm_pkg::CFG_CART_SIZE: cart_size <= cfg_data;
          cbmm_pkg::CFG_BOOT_SIZE: boot_size <= cfg_data[cbmm_pkg::BOOT_SIZE_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + MainAw'(1);
          if (clr_cnt == MainAw'(MAIN_RAM_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            op_q  <= op;
            addr  <= bus_address;
            wbyte <= write_byte;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_byte <= exec_byte;
          res_src  <= exec_src;
          res_off  <= exec_off;
          state    <= exec_next;
          if (op_q == cbmm_pkg::OP_WRITE) begin
            if (region == R_LEGACY) begin
              legacy_regs[reg_idx] <= wbyte;
            end
            if (region == R_DISPLAY) begin
              display_regs[reg_idx] <= wbyte;
              if (reg_idx == cbmm_pkg::DISP_LIST_HI) begin
                list_pointer[15:8] <= wbyte;
              end
              if (reg_idx == cbmm_pkg::DISP_LIST_LO) begin
                list_pointer[7:0] <= wbyte;
              end
            end
          end
        end
        S_RAM: begin
          unique case (region)
            R_LOW:   res_byte <= low_rdata;
            R_IO:    res_byte <= io_rdata;
            default: res_byte <= main_rdata;
          endcase
          state <= S_DONE;
        end
        S_DIV: begin
          if (div_status.done) begin
            res_byte <= 8'h00;
            res_src  <= cbmm_pkg::SRC_CART;
            res_off  <= FW'({1'b0, div_status.rem} & CartMask);
            state    <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid            <= 1'b1;
            read_byte            <= res_byte;
            source               <= res_src;
            fetch_offset         <= res_off;
            display_list_pointer <= list_pointer;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/cbmm_rem_unit.sv =====
// Restoring remainder unit, one dividend bit per cycle.
// Depends on cbmm_pkg.
`default_nettype none

module cbmm_rem_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic [cbmm_pkg::DIVIDEND_W-1:0]     dividend,
  input  wire logic [cbmm_pkg::CART_SIZE_W-1:0]    divisor,
  output cbmm_pkg::rem_status_t                    status
);

  localparam int DW = cbmm_pkg::DIVIDEND_W;
  localparam int RW = cbmm_pkg::CART_SIZE_W;

  logic          busy;
  logic [3:0]    cnt;
  logic [DW-1:0] quo;
  logic [RW-1:0] rem;
  logic [RW-1:0] dvs;
  logic          done;
  logic [RW:0]   trial;
  logic [RW:0]   diff;

  always_comb begin
    trial = {rem, quo[DW-1]};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 4'(DW - 1);
        quo  <= dividend;
        dvs  <= divisor;
        rem  <= '0;
      end else if (busy) begin
        quo <= {quo[DW-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) begin
          rem <= diff[RW-1:0];
        end else begin
          rem <= trial[RW-1:0];
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status.done = done;
  assign status.rem  = rem;

endmodule

`default_nettype wire
